>>> rtl/lcasr_pkg.sv
`timescale 1ns / 1ps

package lcasr_pkg;

    // Default converter word width
    localparam int SAMPLE_BITS_DEF = 24;

    // Fixed field widths
    localparam int SAMPLE_W   = 24;
    localparam int GAIN_W     = 2;
    localparam int WCOUNT_W   = 16;
    localparam int TOL_W      = 25;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 32;
    localparam int M_TUSER_W  = 3;

    // Register reset values
    localparam logic [GAIN_W-1:0]   GAIN_RST   = GAIN_W'(1);
    localparam logic [WCOUNT_W-1:0] WCOUNT_RST = WCOUNT_W'(10);
    localparam logic [TOL_W-1:0]    TOL_RST    = TOL_W'(300);

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_PULSES  = 2'd0,
        CFG_WINDOW_COUNT = 2'd1,
        CFG_TOLERANCE    = 2'd2
    } cfg_index_t;

    // Serial link phase, one-hot
    typedef enum logic [4:0] {
        PH_IDLE       = 5'b00001,
        PH_SHIFT_HIGH = 5'b00010,
        PH_SHIFT_LOW  = 5'b00100,
        PH_PULSE_HIGH = 5'b01000,
        PH_PULSE_LOW  = 5'b10000
    } phase_t;

    // Window tracker status for the sample being emitted
    typedef struct packed {
        logic done;
        logic stable;
    } window_status_t;

endpackage

>>> rtl/lcasr_window.sv
`timescale 1ns / 1ps

module lcasr_window #(
    parameter int SAMPLE_BITS = lcasr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              sample_en,
    input  logic signed [SAMPLE_BITS-1:0]     sample_value,
    input  logic [lcasr_pkg::WCOUNT_W-1:0]    window_count,
    input  logic [lcasr_pkg::TOL_W-1:0]       tolerance,
    output lcasr_pkg::window_status_t         status
);

    localparam int RANGE_W = SAMPLE_BITS + 1;
    localparam int CMP_W   = (RANGE_W > lcasr_pkg::TOL_W) ? RANGE_W : lcasr_pkg::TOL_W;

    logic signed [SAMPLE_BITS-1:0]        max_reg, max_next;
    logic signed [SAMPLE_BITS-1:0]        min_reg, min_next;
    logic [lcasr_pkg::WCOUNT_W-1:0]       fill_reg, fill_inc;
    logic [lcasr_pkg::WCOUNT_W-1:0]       need_win;
    logic signed [RANGE_W-1:0]            range_s;
    logic [RANGE_W-1:0]                   range_u;

    always_comb begin
        if (fill_reg == '0) begin
            max_next = sample_value;
            min_next = sample_value;
        end else begin
            max_next = (sample_value > max_reg) ? sample_value : max_reg;
            min_next = (sample_value < min_reg) ? sample_value : min_reg;
        end
        need_win = (window_count == '0) ? lcasr_pkg::WCOUNT_W'(1) : window_count;
        fill_inc = fill_reg + lcasr_pkg::WCOUNT_W'(1);
        // max never falls below min, so the difference is non-negative
        range_s  = RANGE_W'(max_next) - RANGE_W'(min_next);
        range_u  = range_s;
        status.done   = fill_inc >= need_win;
        status.stable = status.done && (CMP_W'(range_u) < CMP_W'(tolerance));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            max_reg  <= '0;
            min_reg  <= '0;
        end else if (sample_en) begin
            max_reg  <= max_next;
            min_reg  <= min_next;
            fill_reg <= status.done ? '0 : fill_inc;
        end
    end

endmodule

>>> rtl/load_cell_adc_serial_reader.sv
`timescale 1ns / 1ps

// Channel   | Ports                          | Fields (low bit up)
// ----------+--------------------------------+------------------------------------------
// input     | s_tvalid s_tready s_tdata[7:0] | data_line [0]
// result    | m_tvalid m_tready m_tdata[31:0]| clock_out [0], sample [24:1], zero pad
//           | m_tuser[2:0]                   | sample_valid [0], window_done [1], stable [2]
// config    | cfg_wr_en cfg_index cfg_wdata  | 0 gain_pulses, 1 window_count, 2 tolerance
//
// One tick request per cycle unless stalled; its result is in the output register next cycle.
// The rate is set by the single phase/window update path feeding that output register.
// The input side stalls only while the output register is full and m_tready is low.
// aresetn is synchronous, active low: link idle, window empty, registers at defaults.
// No memories, so no clearing pass after reset.

module load_cell_adc_serial_reader #(
    parameter int SAMPLE_BITS = lcasr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input ticks
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lcasr_pkg::S_TDATA_W-1:0]     s_tdata,   // [0] data_line
    // results
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lcasr_pkg::M_TDATA_W-1:0]     m_tdata,   // [0] clock_out, [24:1] sample
    output logic [lcasr_pkg::M_TUSER_W-1:0]     m_tuser,   // [0] valid, [1] done, [2] stable
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [lcasr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lcasr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int BCNT_W = $clog2(SAMPLE_BITS + 1);
    localparam int PAD_W  = lcasr_pkg::M_TDATA_W - lcasr_pkg::SAMPLE_W - 1;

    // configuration registers
    logic [lcasr_pkg::GAIN_W-1:0]   gain_reg;
    logic [lcasr_pkg::WCOUNT_W-1:0] wcount_reg;
    logic [lcasr_pkg::TOL_W-1:0]    tol_reg;

    // link state
    lcasr_pkg::phase_t              phase_reg, phase_next;
    logic [BCNT_W-1:0]              bcnt_reg, bcnt_next;
    logic [1:0]                     pcnt_reg, pcnt_next;
    logic [SAMPLE_BITS-1:0]         shift_reg, shift_next;

    // output register
    logic                           m_valid_reg;
    logic                           clk_out_reg, clk_out_next;
    logic                           svalid_reg, emit;
    logic [lcasr_pkg::SAMPLE_W-1:0] sample_reg, sample_ext;
    logic                           done_reg, stable_reg;

    logic                           tick;
    logic                           din;
    logic [1:0]                     need_pulses;
    lcasr_pkg::window_status_t      win_status;

    // output register frees up in the same cycle it drains
    assign s_tready = !m_valid_reg || m_tready;
    assign tick     = s_tvalid && s_tready;
    assign din      = s_tdata[0];

    // gain setting of zero behaves as one pulse
    assign need_pulses = (gain_reg == '0) ? 2'd1 : gain_reg;

    // low 24 bits of the sign-extended converter word
    for (genvar i = 0; i < lcasr_pkg::SAMPLE_W; i++) begin : g_ext
        if (i < SAMPLE_BITS) begin : g_bit
            assign sample_ext[i] = shift_reg[i];
        end else begin : g_sign
            assign sample_ext[i] = shift_reg[SAMPLE_BITS-1];
        end
    end

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg   <= lcasr_pkg::GAIN_RST;
            wcount_reg <= lcasr_pkg::WCOUNT_RST;
            tol_reg    <= lcasr_pkg::TOL_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                lcasr_pkg::CFG_GAIN_PULSES:  gain_reg   <= cfg_wdata[lcasr_pkg::GAIN_W-1:0];
                lcasr_pkg::CFG_WINDOW_COUNT: wcount_reg <= cfg_wdata[lcasr_pkg::WCOUNT_W-1:0];
                lcasr_pkg::CFG_TOLERANCE:    tol_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // per-tick link sequencing
    always_comb begin
        phase_next   = phase_reg;
        bcnt_next    = bcnt_reg;
        pcnt_next    = pcnt_reg;
        shift_next   = shift_reg;
        clk_out_next = 1'b0;
        emit         = 1'b0;
        unique case (phase_reg)
            lcasr_pkg::PH_IDLE: begin
                // data line low means a conversion is ready
                if (!din) begin
                    bcnt_next  = '0;
                    pcnt_next  = '0;
                    shift_next = '0;
                    phase_next = lcasr_pkg::PH_SHIFT_HIGH;
                end
            end
            lcasr_pkg::PH_SHIFT_HIGH: begin
                clk_out_next = 1'b1;
                shift_next   = {shift_reg[SAMPLE_BITS-2:0], din};
                bcnt_next    = bcnt_reg + BCNT_W'(1);
                phase_next   = lcasr_pkg::PH_SHIFT_LOW;
            end
            lcasr_pkg::PH_SHIFT_LOW: begin
                phase_next = (bcnt_reg >= BCNT_W'(SAMPLE_BITS)) ? lcasr_pkg::PH_PULSE_HIGH
                                                                : lcasr_pkg::PH_SHIFT_HIGH;
            end
            lcasr_pkg::PH_PULSE_HIGH: begin
                clk_out_next = 1'b1;
                pcnt_next    = pcnt_reg + 2'd1;
                phase_next   = lcasr_pkg::PH_PULSE_LOW;
            end
            lcasr_pkg::PH_PULSE_LOW: begin
                // gain is read live, so a mid-frame change takes effect here
                if (pcnt_reg >= need_pulses) begin
                    emit       = 1'b1;
                    phase_next = lcasr_pkg::PH_IDLE;
                end else begin
                    phase_next = lcasr_pkg::PH_PULSE_HIGH;
                end
            end
            default: phase_next = lcasr_pkg::PH_IDLE;
        endcase
    end

    lcasr_window #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .sample_en    (tick && emit),
        .sample_value (shift_reg),
        .window_count (wcount_reg),
        .tolerance    (tol_reg),
        .status       (win_status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= lcasr_pkg::PH_IDLE;
            bcnt_reg  <= '0;
            pcnt_reg  <= '0;
            shift_reg <= '0;
        end else if (tick) begin
            phase_reg <= phase_next;
            bcnt_reg  <= bcnt_next;
            pcnt_reg  <= pcnt_next;
            shift_reg <= shift_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (tick) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload; sample and flags are zero unless a sample is emitted
    always_ff @(posedge aclk) begin
        if (tick) begin
            clk_out_reg <= clk_out_next;
            svalid_reg  <= emit;
            sample_reg  <= emit ? sample_ext : '0;
            done_reg    <= emit && win_status.done;
            stable_reg  <= emit && win_status.stable;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, sample_reg, clk_out_reg};
    assign m_tuser  = {stable_reg, done_reg, svalid_reg};

endmodule
